@@ src/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, codes and helper functions of the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int WORD_W   = 63;   // codeword field width
	localparam int DATA_W   = 57;   // data field width
	localparam int SYND_W   = 6;    // syndrome width
	localparam int LEN_W    = 6;    // data length register width
	localparam int PAR_W    = 3;    // parity count width
	localparam int STATUS_W = 2;

	// Length after reset: four data bits, seven code bits
	localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(4);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_ENCODE = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

	// Smallest r with 2^r >= m + r + 1
	function automatic logic [PAR_W-1:0] parity_count(input logic [LEN_W-1:0] m);
		logic [PAR_W-1:0] r;
		r = '0;
		for (int k = 0; k < 7; k++) begin
			if ((32'd1 << r) < (32'(m) + 32'(r) + 32'd1)) begin
				r = r + PAR_W'(1);
			end
		end
		return r;
	endfunction

	// Largest data length whose codeword fits in max_code bits
	function automatic int max_data_len(input int max_code);
		int res;
		res = 1;
		for (int m = 1; m <= DATA_W; m++) begin
			if (m + int'(parity_count(LEN_W'(m))) <= max_code) begin
				res = m;
			end
		end
		return res;
	endfunction

	// Codeword bits whose position (index + 1) has syndrome bit j set
	function automatic logic [WORD_W-1:0] group_mask(input int j);
		logic [WORD_W-1:0] msk;
		msk = '0;
		for (int i = 1; i <= WORD_W; i++) begin
			msk[i-1] = ((i >> j) & 1) == 1;
		end
		return msk;
	endfunction

endpackage

@@ src/hsc_if.sv @@
// ----------------------------------------------------------------------------
// hsc_req_if / hsc_rsp_if
// Valid/ready channels of the codec: request in, result out.
// ----------------------------------------------------------------------------
interface hsc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [hsc_pkg::WORD_W-1:0] word;

	modport source (output valid, output func, output word, input ready);
	modport sink   (input valid, input func, input word, output ready);
endinterface

interface hsc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hsc_pkg::WORD_W-1:0]   code_word;
	logic [hsc_pkg::DATA_W-1:0]   data_out;
	logic [hsc_pkg::SYND_W-1:0]   syndrome;
	logic [hsc_pkg::STATUS_W-1:0] status;

	modport source (output valid, output code_word, output data_out, output syndrome,
		output status, input ready);
	modport sink   (input valid, input code_word, input data_out, input syndrome,
		input status, output ready);
endinterface

@@ src/hamming_sec_codec_core.sv @@
// ----------------------------------------------------------------------------
// hamming_sec_codec_core
// Even-parity Hamming single-error-correcting encoder/decoder, data length
// set by a register, four-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  --------  ----  --------------  ------------------------------------------
//  req       in    valid / ready   func, word
//  rsp       out   valid / ready   code_word, data_out, syndrome, status
//  cfg       in    cfg_we          cfg_wdata (data length m)
//
//  Four register stages, s1 to s4: a request is registered into s1 when it is
//  accepted and its result is valid once it reaches s4; one request is accepted
//  every cycle while the output is not stalled. Stages: place/mask, syndrome XOR
//  trees, parity insert or correction, data extraction into the output register.
//  A stalled result freezes the whole pipeline; nothing is dropped.
//  Reset clears all valid bits and sets the data length to four.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core #(
	parameter int MAX_CODE_BITS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hsc_pkg::LEN_W-1:0]  cfg_wdata,
	hsc_req_if.sink                    req,
	hsc_rsp_if.source                  rsp
);

	localparam int WORD_W = hsc_pkg::WORD_W;
	localparam int DATA_W = hsc_pkg::DATA_W;
	localparam int SYND_W = hsc_pkg::SYND_W;
	localparam int LEN_W  = hsc_pkg::LEN_W;
	localparam int M_LIMIT = hsc_pkg::max_data_len(MAX_CODE_BITS);

	localparam logic [LEN_W-1:0] RST_N_LEN =
		hsc_pkg::RESET_LEN + LEN_W'(hsc_pkg::parity_count(hsc_pkg::RESET_LEN));

	// ------------------------------------------------------------------
	// Configuration: decode the data length once, at the write.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0]  n_q;        // codeword length
	logic [WORD_W-1:0] nmask_q;    // ones below n
	logic [DATA_W-1:0] dmask_q;    // ones below m

	logic [LEN_W-1:0]  m_new;
	logic [LEN_W-1:0]  n_new;

	always_comb begin
		m_new = cfg_wdata;
		// Treat zero length as one; clamp to what fits the code size
		if (m_new == '0) begin
			m_new = LEN_W'(1);
		end
		if (m_new > LEN_W'(M_LIMIT)) begin
			m_new = LEN_W'(M_LIMIT);
		end
		n_new = m_new + LEN_W'(hsc_pkg::parity_count(m_new));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= RST_N_LEN;
			nmask_q <= {WORD_W{1'b1}} >> (WORD_W - int'(RST_N_LEN));
			dmask_q <= {DATA_W{1'b1}} >> (DATA_W - int'(hsc_pkg::RESET_LEN));
		end else if (cfg_we) begin
			n_q     <= n_new;
			nmask_q <= {WORD_W{1'b1}} >> (7'(WORD_W) - 7'(n_new));
			dmask_q <= {DATA_W{1'b1}} >> (7'(DATA_W) - 7'(m_new));
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: advance every stage while the output can move.
	// ------------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign adv       = !vld_s4 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: scatter data to non-power-of-two positions (encode) or
	// mask the received word to n bits (decode).
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] placed;
	logic [DATA_W-1:0] dat_in;

	always_comb begin
		int k;
		k      = 0;
		dat_in = req.word[DATA_W-1:0] & dmask_q;
		placed = '0;
		for (int i = 1; i <= WORD_W; i++) begin
			if ((i & (i - 1)) != 0) begin
				placed[i-1] = dat_in[k];
				k = k + 1;
			end
		end
	end

	logic              func_s1;
	logic [WORD_W-1:0] cw_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			cw_s1   <= (req.func == hsc_pkg::FUNC_DECODE) ? (req.word & nmask_q) : placed;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: syndrome, one XOR tree per bit over its check group.
	// ------------------------------------------------------------------
	logic [SYND_W-1:0] syn;

	always_comb begin
		for (int j = 0; j < SYND_W; j++) begin
			syn[j] = ^(cw_s1 & hsc_pkg::group_mask(j));
		end
	end

	logic              func_s2;
	logic [WORD_W-1:0] cw_s2;
	logic [SYND_W-1:0] syn_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2 <= func_s1;
			cw_s2   <= cw_s1;
			syn_s2  <= syn;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: encode sets the parity bits from the syndrome (those
	// positions are still zero); decode flips the addressed bit, or flags
	// a syndrome that points past the codeword.
	// ------------------------------------------------------------------
	logic [WORD_W-1:0]    cw_fix;
	logic [SYND_W-1:0]    syn_fix;
	hsc_pkg::status_t     st_fix;

	always_comb begin
		cw_fix  = cw_s2;
		syn_fix = '0;
		st_fix  = hsc_pkg::ST_OK;
		if (func_s2 == hsc_pkg::FUNC_ENCODE) begin
			for (int j = 0; j < SYND_W; j++) begin
				cw_fix[(1 << j) - 1] = syn_s2[j];
			end
		end else begin
			syn_fix = syn_s2;
			if (syn_s2 != '0) begin
				if (syn_s2 <= n_q) begin
					cw_fix = cw_s2 ^ (WORD_W'(1) << (syn_s2 - SYND_W'(1)));
					st_fix = hsc_pkg::ST_CORRECTED;
				end else begin
					st_fix = hsc_pkg::ST_RANGE;
				end
			end
		end
	end

	logic [WORD_W-1:0] cw_s3;
	logic [SYND_W-1:0] syn_s3;
	hsc_pkg::status_t  st_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cw_s3  <= cw_fix;
			syn_s3 <= syn_fix;
			st_s3  <= st_fix;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: gather the data bits into the output register. Bits above
	// n are zero, so data above m comes out zero.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] gathered;

	always_comb begin
		int k;
		k        = 0;
		gathered = '0;
		for (int i = 1; i <= WORD_W; i++) begin
			if ((i & (i - 1)) != 0) begin
				gathered[k] = cw_s3[i-1];
				k = k + 1;
			end
		end
	end

	logic [WORD_W-1:0] cw_s4;
	logic [DATA_W-1:0] dat_s4;
	logic [SYND_W-1:0] syn_s4;
	hsc_pkg::status_t  st_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			cw_s4  <= cw_s3;
			dat_s4 <= gathered;
			syn_s4 <= syn_s3;
			st_s4  <= st_s3;
		end
	end

	assign rsp.valid     = vld_s4;
	assign rsp.code_word = cw_s4;
	assign rsp.data_out  = dat_s4;
	assign rsp.syndrome  = syn_s4;
	assign rsp.status    = st_s4;

endmodule
